FILE: sv/bst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_pkg
// Shared widths, opcodes and the cell-to-cell link type for the sorted
// top-k insertion table.
// ----------------------------------------------------------------------------
package bst_pkg;

  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned PAYLOAD_W = 48;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned DEPTH_DEF = 16;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // what one cell hands to the next one down the row
  typedef struct packed {
    logic                 valid;
    logic                 take;
    logic [SCORE_W-1:0]   score;
    logic [PAYLOAD_W-1:0] payload;
  } link_t;

endpackage

FILE: sv/bst_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bst_cell
// One slot of the sorted table: holds a record, decides whether the new
// record lands here or whether it takes the record of the slot above.
// ----------------------------------------------------------------------------
module bst_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          shift_en,
  input  logic [bst_pkg::SCORE_W-1:0]   new_score,
  input  logic [bst_pkg::PAYLOAD_W-1:0] new_payload,
  input  bst_pkg::link_t                up,
  output bst_pkg::link_t                down,
  output logic                          hit
);

  logic                          valid;
  logic [bst_pkg::SCORE_W-1:0]   score;
  logic [bst_pkg::PAYLOAD_W-1:0] payload;
  logic                          take;
  logic                          load_new;
  logic                          load_up;

  // take is monotonic down the row since the table stays sorted
  always_comb begin
    take     = !valid || (new_score > score);
    load_new = take && up.valid && !up.take;
    load_up  = take && up.valid && up.take;
    hit      = load_new;
    down     = '{valid: valid, take: take, score: score, payload: payload};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift_en && (load_new || load_up)) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      if (load_new) begin
        score   <= new_score;
        payload <= new_payload;
      end else if (load_up) begin
        score   <= up.score;
        payload <= up.payload;
      end
    end
  end

endmodule

FILE: sv/bounded_sorted_topk_insert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sorted_topk_insert_core
// Sorted top-k table built as a row of cells, highest score first.
//
//   channel   strobe     fields
//   command   start      op, new_score, new_payload, read_index (busy stays low)
//   result    done       accepted, position, entry_valid, out_score,
//                        out_payload, entry_count
//
// One command word per cycle; its result word shows on done in the next cycle.
// Every cell compares the new score against its own in the same cycle and
// shifts from its upper neighbor, so the whole row settles together on the insert's edge.
// Reset clears the valid bits of all cells and the count; no clearing pass.
// The receiver cannot stall: each result holds only until the next command's result replaces it.
// ----------------------------------------------------------------------------
module bounded_sorted_topk_insert_core #(
  parameter int unsigned DEPTH = bst_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [bst_pkg::SCORE_W-1:0]   new_score,
  input  logic [bst_pkg::PAYLOAD_W-1:0] new_payload,
  input  logic [bst_pkg::IDX_W-1:0]     read_index,
  output logic                          done,
  output logic                          accepted,
  output logic [bst_pkg::POS_W-1:0]     position,
  output logic                          entry_valid,
  output logic [bst_pkg::SCORE_W-1:0]   out_score,
  output logic [bst_pkg::PAYLOAD_W-1:0] out_payload,
  output logic [bst_pkg::COUNT_W-1:0]   entry_count
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned RD = (1 << bst_pkg::IDX_W);

  bst_pkg::link_t link [DEPTH+1];
  logic [DEPTH-1:0] hit;

  logic                          is_insert;
  logic                          shift_en;
  logic                          ins_ok;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 count_next;
  logic [IW-1:0]                 pos;
  logic                          rd_hit;
  logic [bst_pkg::SCORE_W-1:0]   rd_score;
  logic [bst_pkg::PAYLOAD_W-1:0] rd_payload;

  // a word is taken every cycle
  assign busy = 1'b0;

  // row head: always valid and never takes, so cell 0 loads the new record
  assign link[0] = '{valid: 1'b1, take: 1'b0, score: '0, payload: '0};

  assign is_insert = start && (op == bst_pkg::OP_INSERT);
  // last cell refuses only when full and the score is not above its own
  assign ins_ok    = link[DEPTH].take;
  assign shift_en  = is_insert && ins_ok;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    bst_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .shift_en    (shift_en),
      .new_score   (new_score),
      .new_payload (new_payload),
      .up          (link[g]),
      .down        (link[g+1]),
      .hit         (hit[g])
    );
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit[i]) begin
        pos = pos | IW'(i);
      end
    end
  end

  // valid bits are set from the top, so a valid cell lies below the count
  always_comb begin
    rd_hit     = 1'b0;
    rd_score   = '0;
    rd_payload = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i < RD) begin
        if (link[i+1].valid && (read_index == bst_pkg::IDX_W'(i))) begin
          rd_hit     = 1'b1;
          rd_score   = rd_score | link[i+1].score;
          rd_payload = rd_payload | link[i+1].payload;
        end
      end
    end
  end

  always_comb begin
    count_next = count;
    if (shift_en && !link[DEPTH].valid) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      entry_count <= bst_pkg::COUNT_W'(count_next);
      if (op == bst_pkg::OP_INSERT) begin
        accepted    <= ins_ok;
        position    <= ins_ok ? bst_pkg::POS_W'(pos) : '0;
        entry_valid <= 1'b0;
        out_score   <= '0;
        out_payload <= '0;
      end else begin
        accepted    <= 1'b0;
        position    <= '0;
        entry_valid <= rd_hit;
        out_score   <= rd_score;
        out_payload <= rd_payload;
      end
    end
  end

endmodule

FILE: verif/bounded_sorted_topk_insert_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sorted_topk_insert_core_tb
// Drives insert and read words into the sorted top-k table and checks
// every result word against a behavioral copy of the table kept here.
// Directed words cover empty, partial and full tables, ties, the extreme
// scores and rejected inserts; random words follow in three pacing phases.
// ----------------------------------------------------------------------------
module bounded_sorted_topk_insert_core_tb;

  localparam int TABLE_DEPTH = bst_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic                          op;
    logic [bst_pkg::SCORE_W-1:0]   score;
    logic [bst_pkg::PAYLOAD_W-1:0] payload;
    logic [bst_pkg::IDX_W-1:0]     index;
    int                            gap_pct;
    bit                            drain;
  } cmd_t;

  typedef struct {
    logic                          accepted;
    logic [bst_pkg::POS_W-1:0]     position;
    logic                          entry_valid;
    logic [bst_pkg::SCORE_W-1:0]   out_score;
    logic [bst_pkg::PAYLOAD_W-1:0] out_payload;
    logic [bst_pkg::COUNT_W-1:0]   entry_count;
  } result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          op = bst_pkg::OP_INSERT;
  logic [bst_pkg::SCORE_W-1:0]   new_score = '0;
  logic [bst_pkg::PAYLOAD_W-1:0] new_payload = '0;
  logic [bst_pkg::IDX_W-1:0]     read_index = '0;
  logic                          done;
  logic                          accepted;
  logic [bst_pkg::POS_W-1:0]     position;
  logic                          entry_valid;
  logic [bst_pkg::SCORE_W-1:0]   out_score;
  logic [bst_pkg::PAYLOAD_W-1:0] out_payload;
  logic [bst_pkg::COUNT_W-1:0]   entry_count;

  cmd_t    pending_cmds[$];
  result_t expected_words[$];
  cmd_t    cur_cmd;
  int      errors = 0;
  int      cycles = 0;

  // table copy, highest score first
  logic [bst_pkg::SCORE_W-1:0]   ranked_score[TABLE_DEPTH];
  logic [bst_pkg::PAYLOAD_W-1:0] ranked_payload[TABLE_DEPTH];
  int                            held = 0;

  bounded_sorted_topk_insert_core dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .new_score   (new_score),
    .new_payload (new_payload),
    .read_index  (read_index),
    .done        (done),
    .accepted    (accepted),
    .position    (position),
    .entry_valid (entry_valid),
    .out_score   (out_score),
    .out_payload (out_payload),
    .entry_count (entry_count)
  );

  always #5 clk = ~clk;

  function automatic result_t rank_and_place(cmd_t c);
    result_t r;
    int      slot;
    r = '{default: '0};
    if (c.op == bst_pkg::OP_INSERT) begin
      slot = 0;
      // ties go behind the older entries
      while (slot < held && c.score <= ranked_score[slot]) slot++;
      if (slot < TABLE_DEPTH) begin
        if (held < TABLE_DEPTH) held++;
        for (int i = held - 1; i > slot; i--) begin
          ranked_score[i]   = ranked_score[i-1];
          ranked_payload[i] = ranked_payload[i-1];
        end
        ranked_score[slot]   = c.score;
        ranked_payload[slot] = c.payload;
        r.accepted = 1'b1;
        r.position = bst_pkg::POS_W'(slot);
      end
    end else if (int'(c.index) < held) begin
      r.entry_valid = 1'b1;
      r.out_score   = ranked_score[c.index];
      r.out_payload = ranked_payload[c.index];
    end
    r.entry_count = bst_pkg::COUNT_W'(held);
    return r;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  task automatic queue_cmd(input logic o, input logic [bst_pkg::SCORE_W-1:0] s,
                           input logic [bst_pkg::PAYLOAD_W-1:0] p,
                           input logic [bst_pkg::IDX_W-1:0] x,
                           input int gap, input bit drain);
    cmd_t c;
    c.op      = o;
    c.score   = s;
    c.payload = p;
    c.index   = x;
    c.gap_pct = gap;
    c.drain   = drain;
    pending_cmds.push_back(c);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_words.push_back(rank_and_place(cur_cmd));
      end
      if (!start || !busy) begin
        if (pending_cmds.size() > 0 &&
            $urandom_range(99) >= pending_cmds[0].gap_pct &&
            (!pending_cmds[0].drain ||
             (expected_words.size() == 0 && !(start && !busy)))) begin
          cur_cmd = pending_cmds.pop_front();
          start       <= 1'b1;
          op          <= cur_cmd.op;
          new_score   <= cur_cmd.score;
          new_payload <= cur_cmd.payload;
          read_index  <= cur_cmd.index;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_words.size() == 0) begin
        $display("%0t: result word expected none actual count %0h",
                 $time, entry_count);
        errors++;
      end else begin
        want = expected_words.pop_front();
        check_field("accepted", 64'(want.accepted), 64'(accepted));
        check_field("position", 64'(want.position), 64'(position));
        check_field("entry_valid", 64'(want.entry_valid), 64'(entry_valid));
        check_field("out_score", 64'(want.out_score), 64'(out_score));
        check_field("out_payload", 64'(want.out_payload), 64'(out_payload));
        check_field("entry_count", 64'(want.entry_count), 64'(entry_count));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [63:0]                 wide;
    logic [bst_pkg::SCORE_W-1:0] sc;
    int                          gap;

    // reads on an empty table
    queue_cmd(bst_pkg::OP_READ, '0, '0, 4'd0, 37, 1'b0);
    queue_cmd(bst_pkg::OP_READ, '1, '1, 4'd15, 37, 1'b0);
    // equal scores land behind the older one
    queue_cmd(bst_pkg::OP_INSERT, 32'd100, 48'h0000_0000_00AA, 4'd0, 37, 1'b0);
    queue_cmd(bst_pkg::OP_INSERT, 32'd100, 48'h0000_0000_00BB, 4'd0, 37, 1'b0);
    queue_cmd(bst_pkg::OP_INSERT, '1, '1, 4'd0, 37, 1'b0);
    queue_cmd(bst_pkg::OP_INSERT, '0, '0, 4'd15, 37, 1'b0);
    queue_cmd(bst_pkg::OP_INSERT, 32'd50, 48'h8000_0000_0001, 4'd0, 37, 1'b0);
    // last valid entry, then just past the count
    queue_cmd(bst_pkg::OP_READ, '0, '0, 4'd4, 37, 1'b0);
    queue_cmd(bst_pkg::OP_READ, '0, '0, 4'd5, 37, 1'b0);
    queue_cmd(bst_pkg::OP_READ, '0, '0, 4'd15, 37, 1'b0);
    for (int i = 0; i < 11; i++) begin
      queue_cmd(bst_pkg::OP_INSERT, 32'd200 + i, 48'(64'h5555_5555_5555 + i), 4'd0,
                37, 1'b0);
    end
    // full table: equal to the lowest is dropped, one above it evicts it
    queue_cmd(bst_pkg::OP_INSERT, '0, 48'h1234_5678_9ABC, 4'd0, 37, 1'b0);
    queue_cmd(bst_pkg::OP_INSERT, 32'd1, 48'hFEDC_BA98_7654, 4'd0, 37, 1'b0);
    queue_cmd(bst_pkg::OP_INSERT, '1, 48'h0F0F_0F0F_0F0F, 4'd0, 37, 1'b0);
    queue_cmd(bst_pkg::OP_READ, '0, '0, 4'd15, 37, 1'b0);
    queue_cmd(bst_pkg::OP_READ, '0, '0, 4'd1, 37, 1'b0);

    for (int n = 0; n < 700; n++) begin
      gap  = (n < 230) ? 37 : ((n < 460) ? 87 : 0);
      wide = {$urandom, $urandom};
      case ($urandom_range(9))
        0, 1, 2: sc = $urandom;
        3, 4:    sc = $urandom_range(63);
        8:       sc = '0;
        9:       sc = '1;
        default: sc = 32'hFFFF_FFFF - $urandom_range(63);
      endcase
      queue_cmd(($urandom_range(99) < 60) ? bst_pkg::OP_INSERT : bst_pkg::OP_READ,
                sc, wide[47:0], bst_pkg::IDX_W'($urandom_range(15)), gap,
                n == 115 || n == 230 || n == 460);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (pending_cmds.size() != 0 || start || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
